[design/psc_pkg.sv]
`default_nettype none

package psc_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 3'd4;

    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned GAIN_W     = 12;
    localparam int unsigned LIMIT_W    = 15;

    // reset values of the registers
    localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN    = 12'd256;
    localparam logic [GAIN_W-1:0]  RST_TURN_GAIN     = 12'd1024;
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT   = 15'd2048;
    localparam logic [LIMIT_W-1:0] RST_TURN_LIMIT    = 15'd4096;
    localparam logic [LIMIT_W-1:0] RST_STOP_DISTANCE = 15'd205;

    // cordic datapath widths and step count
    localparam int unsigned CORDIC_STEPS = 17;
    localparam int unsigned CW           = 20;
    localparam int unsigned AW           = 20;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [AW-1:0] t_acc;
    typedef t_acc t_atan_tab [CORDIC_STEPS];

    // angle constants: q3.13 for the error, 2^-16 rad for the accumulator
    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam t_acc               PI_Q16     = 20'sd205887;

    // arctangent of 2^-k in 2^-16 rad, rounded (k = 1 is one unit low)
    localparam t_atan_tab ATAN_TAB = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1
    };

endpackage

`default_nettype wire

[design/pursuit_steering_controller.sv]
`default_nettype none

// channel   dir  handshake               payload
// s (pose)  in   i_s_tvalid/o_s_tready   tdata: own_x, own_y, own_heading, goal_x, goal_y
//                                        tuser: own_known, goal_known
// m (cmd)   out  o_m_tvalid/i_m_tready   tdata: forward_speed, turn_rate; tuser: arrived
// cfg       in   i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// one pose beat a cycle while o_s_tready is high; a command passes through
// three setup stages, 17 square root / cordic stages and four command stages
// a pose with either known flag low passes down as a bubble and yields no beat
// a stalled output fills the output register, then a skid register; only then
// does the whole pipeline hold and o_s_tready fall
// synchronous active-low reset clears valid bits and restores the registers

module pursuit_steering_controller
    import psc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // own_x[15:0], own_y[31:16], own_heading[47:32], goal_x[63:48], goal_y[79:64]
    input  wire logic [79:0]           i_s_tdata,
    // own_known[0], goal_known[1]
    input  wire logic [1:0]            i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // forward_speed[14:0], turn_rate[30:15], zero[31]
    output logic [31:0]                o_m_tdata,
    // arrived[0]
    output logic                       o_m_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned NPIPE = CORDIC_STEPS + 1;
    localparam int unsigned NSTG  = NPIPE + 5;
    localparam int unsigned S_A   = 0;
    localparam int unsigned S_B   = 1;
    localparam int unsigned S_C   = 2;
    localparam int unsigned S_D   = S_C + NPIPE;
    localparam int unsigned S_E   = S_D + 1;
    localparam int unsigned S_F   = S_E + 1;

    // configuration registers
    logic [GAIN_W-1:0]  r_speed_gain;
    logic [GAIN_W-1:0]  r_turn_gain;
    logic [LIMIT_W-1:0] r_speed_limit;
    logic [LIMIT_W-1:0] r_turn_limit;
    logic [LIMIT_W-1:0] r_stop_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain    <= RST_SPEED_GAIN;
            r_turn_gain     <= RST_TURN_GAIN;
            r_speed_limit   <= RST_SPEED_LIMIT;
            r_turn_limit    <= RST_TURN_LIMIT;
            r_stop_distance <= RST_STOP_DISTANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPEED_GAIN:    r_speed_gain    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_TURN_GAIN:     r_turn_gain     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_wdata;
                CFG_TURN_LIMIT:    r_turn_limit    <= i_cfg_wdata;
                CFG_STOP_DISTANCE: r_stop_distance <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline enable: everything moves unless the skid register is full
    logic            w_en;
    logic [NSTG-1:0] r_vld;
    logic            r_skid_vld;

    assign w_en       = !r_skid_vld;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid & i_s_tuser[0] & i_s_tuser[1]};
        end
    end

    // stage a: offsets to the goal
    logic signed [16:0] r_a_dx;
    logic signed [16:0] r_a_dy;
    logic signed [15:0] r_a_hd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_dx <= $signed({i_s_tdata[63], i_s_tdata[63:48]})
                    - $signed({i_s_tdata[15], i_s_tdata[15:0]});
            r_a_dy <= $signed({i_s_tdata[79], i_s_tdata[79:64]})
                    - $signed({i_s_tdata[31], i_s_tdata[31:16]});
            r_a_hd <= $signed(i_s_tdata[47:32]);
        end
    end

    // stage b: squares, and fold the vector into the right half plane
    logic signed [33:0] w_sqx;
    logic signed [33:0] w_sqy;
    logic [31:0]        r_b_sqx;
    logic [31:0]        r_b_sqy;
    t_coord             r_b_x;
    t_coord             r_b_y;
    t_acc               r_b_acc;
    logic               r_b_zero;
    logic signed [15:0] r_b_hd;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_sqx  <= w_sqx[31:0];
            r_b_sqy  <= w_sqy[31:0];
            r_b_zero <= (r_a_dx == 17'sd0) && (r_a_dy == 17'sd0);
            r_b_hd   <= r_a_hd;
            if (r_a_dx[16]) begin
                r_b_x   <= -CW'(r_a_dx);
                r_b_y   <= -CW'(r_a_dy);
                r_b_acc <= r_a_dy[16] ? -PI_Q16 : PI_Q16;
            end else begin
                r_b_x   <= CW'(r_a_dx);
                r_b_y   <= CW'(r_a_dy);
                r_b_acc <= '0;
            end
        end
    end

    // stage c is element 0 of the iteration arrays: squared length
    logic [33:0]        r_p_n    [NPIPE-1];
    logic [19:0]        r_p_rem  [NPIPE-1];
    logic [16:0]        r_p_root [NPIPE];
    t_coord             r_p_x    [NPIPE-1];
    t_coord             r_p_y    [NPIPE-1];
    t_acc               r_p_acc  [NPIPE];
    logic               r_p_zero [NPIPE];
    logic signed [15:0] r_p_hd   [NPIPE];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_n[0]    <= {1'b0, {1'b0, r_b_sqx} + {1'b0, r_b_sqy}};
            r_p_rem[0]  <= '0;
            r_p_root[0] <= '0;
            r_p_x[0]    <= r_b_x;
            r_p_y[0]    <= r_b_y;
            r_p_acc[0]  <= r_b_acc;
            r_p_zero[0] <= r_b_zero;
            r_p_hd[0]   <= r_b_hd;
        end
    end

    // one root bit and one cordic rotation per stage; the last stage updates only the root and the angle
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        localparam int unsigned PAIR = CORDIC_STEPS - 1 - k;

        logic [19:0] n_rem_sh;
        logic [19:0] n_trial;
        logic        n_take;
        t_coord      n_xs;
        t_coord      n_ys;
        logic        n_up;

        assign n_rem_sh = {r_p_rem[k][17:0], r_p_n[k][2*PAIR+1 -: 2]};
        assign n_trial  = {1'b0, r_p_root[k], 2'b01};
        assign n_take   = (n_rem_sh >= n_trial);
        assign n_xs     = r_p_x[k] >>> k;
        assign n_ys     = r_p_y[k] >>> k;
        assign n_up     = !r_p_y[k][CW-1];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_p_root[k+1] <= {r_p_root[k][15:0], n_take};
                r_p_acc[k+1]  <= n_up ? r_p_acc[k] + ATAN_TAB[k]
                                      : r_p_acc[k] - ATAN_TAB[k];
                r_p_zero[k+1] <= r_p_zero[k];
                r_p_hd[k+1]   <= r_p_hd[k];
            end
        end

        if (k < CORDIC_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_p_n[k+1]   <= r_p_n[k];
                    r_p_rem[k+1] <= n_take ? n_rem_sh - n_trial : n_rem_sh;
                    r_p_x[k+1]   <= n_up ? r_p_x[k] + n_ys : r_p_x[k] - n_ys;
                    r_p_y[k+1]   <= n_up ? r_p_y[k] - n_xs : r_p_y[k] + n_xs;
                end
            end
        end
    end

    // stage d: bearing rounding, raw heading error, speed product, stop test
    t_acc               w_bsum;
    logic signed [16:0] w_bear;
    logic signed [17:0] r_d_err;
    logic [28:0]        r_d_sprod;
    logic               r_d_stop;

    assign w_bsum = r_p_acc[NPIPE-1] + t_acc'(4);
    assign w_bear = r_p_zero[NPIPE-1] ? 17'sd0 : w_bsum[AW-1:3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_err   <= $signed({w_bear[16], w_bear})
                       - $signed({{2{r_p_hd[NPIPE-1][15]}}, r_p_hd[NPIPE-1]});
            r_d_sprod <= 29'(r_speed_gain) * 29'(r_p_root[NPIPE-1]);
            r_d_stop  <= (r_p_root[NPIPE-1] < {2'b00, r_stop_distance});
        end
    end

    // stage e: wrap the error, saturate and clamp the speed
    logic signed [17:0] w_wrap;
    logic [20:0]        w_sraw;
    logic [14:0]        w_ssat;
    logic signed [15:0] r_e_err;
    logic [14:0]        r_e_speed;
    logic               r_e_stop;

    always_comb begin
        priority if (r_d_err > PI_Q13) begin
            w_wrap = r_d_err - TWO_PI_Q13;
        end else if (r_d_err < -PI_Q13) begin
            w_wrap = r_d_err + TWO_PI_Q13;
        end else begin
            w_wrap = r_d_err;
        end
    end

    assign w_sraw = r_d_sprod[28:8];
    assign w_ssat = (w_sraw > 21'd32767) ? 15'h7FFF : w_sraw[14:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_err   <= w_wrap[15:0];
            r_e_speed <= (w_ssat > r_speed_limit) ? r_speed_limit : w_ssat;
            r_e_stop  <= r_d_stop;
        end
    end

    // stage f: turn product
    logic signed [28:0] r_f_tprod;
    logic [14:0]        r_f_speed;
    logic               r_f_stop;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_tprod <= $signed({1'b0, r_turn_gain}) * r_e_err;
            r_f_speed <= r_e_speed;
            r_f_stop  <= r_e_stop;
        end
    end

    // command: scale, saturate and clamp the turn rate, zero on arrival
    logic signed [17:0] w_tsh;
    logic signed [17:0] w_tsat;
    logic signed [17:0] w_tlim;
    logic signed [17:0] w_tclp;
    logic [14:0]        n_speed;
    logic signed [15:0] n_turn;
    logic               n_arr;

    assign w_tsh  = r_f_tprod[28:11];
    assign w_tlim = $signed({3'b000, r_turn_limit});

    always_comb begin
        priority if (w_tsh > 18'sd32767) begin
            w_tsat = 18'sd32767;
        end else if (w_tsh < -18'sd32767) begin
            w_tsat = -18'sd32767;
        end else begin
            w_tsat = w_tsh;
        end
        priority if (w_tsat > w_tlim) begin
            w_tclp = w_tlim;
        end else if (w_tsat < -w_tlim) begin
            w_tclp = -w_tlim;
        end else begin
            w_tclp = w_tsat;
        end
        if (r_f_stop) begin
            n_speed = '0;
            n_turn  = '0;
            n_arr   = 1'b1;
        end else begin
            n_speed = r_f_speed;
            n_turn  = w_tclp[15:0];
            n_arr   = 1'b0;
        end
    end

    // output register with a skid register behind it
    logic               r_out_vld;
    logic [14:0]        r_out_speed;
    logic signed [15:0] r_out_turn;
    logic               r_out_arr;
    logic [14:0]        r_skid_speed;
    logic signed [15:0] r_skid_turn;
    logic               r_skid_arr;
    logic               w_out_free;

    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (r_skid_vld) begin
                if (w_out_free) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[S_F]) begin
                if (w_out_free) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_out_free) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_speed <= r_skid_speed;
                r_out_turn  <= r_skid_turn;
                r_out_arr   <= r_skid_arr;
            end
        end else if (w_out_free) begin
            r_out_speed <= n_speed;
            r_out_turn  <= n_turn;
            r_out_arr   <= n_arr;
        end else begin
            r_skid_speed <= n_speed;
            r_skid_turn  <= n_turn;
            r_skid_arr   <= n_arr;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_turn, r_out_speed};
    assign o_m_tuser  = r_out_arr;

`ifndef SYNTHESIS
    // a held input side means the output register and skid are both taken
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && r_skid_vld))
        else $error("input held while output side has room");

    // an arrival beat carries zero commands
    a_arrive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("arrival beat with non-zero command");

    // commands stay inside the configured limits
    a_speed_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_speed <= r_speed_limit))
        else $error("forward speed beyond limit");

    a_turn_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid
        |-> (($signed({r_out_turn[15], r_out_turn}) <= $signed({2'b00, r_turn_limit}))
          && ($signed({r_out_turn[15], r_out_turn}) >= -$signed({2'b00, r_turn_limit}))))
        else $error("turn rate beyond limit");
`endif

endmodule

`default_nettype wire
